### src/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("port check failed");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

### src/bpa_pkg.sv
// Constants and codes for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;
    localparam int NUM_PAGES = 4096;
    localparam int TOP_ORDER = 10;
    localparam int PG_W      = $clog2(NUM_PAGES);
    localparam int LINK_W    = PG_W + 1;
    localparam int ORD_W     = 4;
    localparam int HEADS     = TOP_ORDER + 1;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_PAGES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ORD  = 2'd1;
    localparam logic [1:0] ST_NO_MEM   = 2'd2;
    localparam logic [1:0] ST_BAD_PAGE = 2'd3;

    // Register index of the pool size register.
    localparam logic REG_POOL = 1'b0;
endpackage

### src/buddy_page_allocator.sv
// Buddy page allocator: sequencer, free-list heads and page link memories.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  command   | start / busy          | i_opcode, i_block_order, i_page_index
//  result    | o_done (1-cycle)      | o_status, o_block_page, o_free_pages
//  config    | psel/penable/pwrite   | paddr, pwdata, prdata (pool_pages)
//
// One command at a time; an unlink reads the page memories and then writes
// them, a push writes them directly. Alloc scans orders upward for a free
// block and splits it down to the asked order; free merges with free buddies.
// Reset or a pool_pages write runs a clearing pass over the page state and
// then a list rebuild; busy stays high meanwhile.
// The result is a single-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
module buddy_page_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [3:0]                 i_block_order,
    input  logic [11:0]                i_page_index,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [11:0]                o_block_page,
    output logic [12:0]                o_free_pages,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int PW = bpa_pkg::PG_W;
    localparam int LW = bpa_pkg::LINK_W;
    localparam int OW = bpa_pkg::ORD_W;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_BUILD = 12'b0000_0000_0010,
        S_IDLE  = 12'b0000_0000_0100,
        S_SCAN  = 12'b0000_0000_1000,
        S_UNL   = 12'b0000_0001_0000,
        S_SPLIT = 12'b0000_0010_0000,
        S_FCHK  = 12'b0000_0100_0000,
        S_MTEST = 12'b0000_1000_0000,
        S_MRG   = 12'b0001_0000_0000,
        S_PUSHA = 12'b0010_0000_0000,
        S_PUSHB = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    // Page memories: links and {free flag, order}.
    logic [LW-1:0]   r_mem_next [bpa_pkg::NUM_PAGES];
    logic [LW-1:0]   r_mem_prev [bpa_pkg::NUM_PAGES];
    logic [OW:0]     r_mem_meta [bpa_pkg::NUM_PAGES];
    logic [LW-1:0]   r_rd_next;
    logic [LW-1:0]   r_rd_prev;
    logic [OW:0]     r_rd_meta;
    logic [PW-1:0]   r_rd_addr;

    logic [LW-1:0]   r_head [bpa_pkg::HEADS];

    t_state          r_state;
    t_state          n_state;
    t_state          r_ret;
    logic [LW-1:0]   r_pool;
    logic [LW-1:0]   r_count;
    logic [LW-1:0]   r_left;
    logic [LW-1:0]   r_base;
    logic [PW-1:0]   r_clr;
    logic [OW-1:0]   r_ord;
    logic [OW-1:0]   r_cur;
    logic [PW-1:0]   r_p;
    logic [PW-1:0]   r_blk;
    logic [1:0]      r_status;
    logic [OW-1:0]   r_push_ord;
    logic [PW-1:0]   r_push_pg;
    logic [LW-1:0]   r_push_h;

    logic            w_cfg_wr;
    logic [LW-1:0]   w_cfg_val;
    logic [PW-1:0]   w_rd_addr;
    logic            w_next_we, w_prev_we, w_meta_we;
    logic [PW-1:0]   w_next_addr, w_prev_addr, w_meta_addr;
    logic [LW-1:0]   w_next_wd, w_prev_wd;
    logic [OW:0]     w_meta_wd;
    logic [LW-1:0]   w_head_cur;
    logic [PW-1:0]   w_bd;
    logic            w_merge;
    logic            w_unl;
    logic [LW-1:0]   w_sz_in;
    logic [LW-1:0]   w_sz_ord;
    logic [LW-1:0]   w_sz_cur;
    logic [LW:0]     w_free_sum;
    logic [LW-1:0]   w_free_cnt;
    logic [PW-1:0]   w_split_pg;
    logic [PW-1:0]   w_merge_mask;

    // Decode the config write and saturate the pool size.
    assign w_cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == bpa_pkg::REG_POOL);
    assign w_cfg_val = (pwdata[LW-1:0] > bpa_pkg::NIL_LINK) ? bpa_pkg::NIL_LINK
                                                            : pwdata[LW-1:0];
    assign pready    = 1'b1;
    assign prdata    = {{(32-LW){1'b0}}, r_pool};

    // Derive sizes, buddy and merged counts.
    assign w_head_cur   = (r_cur > OW'(bpa_pkg::TOP_ORDER)) ? bpa_pkg::NIL_LINK
                                                            : r_head[r_cur];
    assign w_bd         = r_p ^ (PW'(1) << r_cur);
    assign w_merge      = r_rd_meta[OW] && (r_rd_meta[OW-1:0] == r_cur);
    assign w_unl        = (r_state == S_UNL) || ((r_state == S_MRG) && w_merge);
    assign w_sz_in      = LW'(1) << i_block_order;
    assign w_sz_ord     = LW'(1) << r_ord;
    assign w_sz_cur     = LW'(1) << r_cur;
    assign w_free_sum   = {1'b0, r_count} + {1'b0, w_sz_ord};
    assign w_free_cnt   = (w_free_sum > {1'b0, r_pool}) ? r_pool : w_free_sum[LW-1:0];
    assign w_split_pg   = r_p + (PW'(1) << (r_cur - OW'(1)));
    assign w_merge_mask = (PW'(2) << r_cur) - PW'(1);

    // Select memory read address and write ports for this step.
    always_comb begin
        w_rd_addr   = r_rd_addr;
        w_next_we   = 1'b0;
        w_prev_we   = 1'b0;
        w_meta_we   = 1'b0;
        w_next_addr = r_push_pg;
        w_prev_addr = r_push_pg;
        w_meta_addr = r_push_pg;
        w_next_wd   = r_rd_next;
        w_prev_wd   = r_rd_prev;
        w_meta_wd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_meta_we   = 1'b1;
                w_meta_addr = r_clr;
            end
            S_IDLE:  w_rd_addr = i_page_index;
            S_SCAN:  w_rd_addr = w_head_cur[PW-1:0];
            S_MTEST: w_rd_addr = w_bd;
            S_PUSHA: begin
                w_next_we = 1'b1;
                w_next_wd = r_head[r_push_ord];
                w_prev_we = 1'b1;
                w_prev_wd = bpa_pkg::NIL_LINK;
                w_meta_we = 1'b1;
                w_meta_wd = {1'b1, r_push_ord};
            end
            S_PUSHB: begin
                w_prev_we   = (r_push_h != bpa_pkg::NIL_LINK);
                w_prev_addr = r_push_h[PW-1:0];
                w_prev_wd   = {1'b0, r_push_pg};
            end
            default: ;
        endcase
        // Unlink the block just read: patch neighbors, clear its free flag.
        if (w_unl) begin
            w_next_we   = (r_rd_prev != bpa_pkg::NIL_LINK);
            w_next_addr = r_rd_prev[PW-1:0];
            w_next_wd   = r_rd_next;
            w_prev_we   = (r_rd_next != bpa_pkg::NIL_LINK);
            w_prev_addr = r_rd_next[PW-1:0];
            w_prev_wd   = r_rd_prev;
            w_meta_we   = 1'b1;
            w_meta_addr = r_rd_addr;
            w_meta_wd   = {1'b0, r_rd_meta[OW-1:0]};
        end
    end

    // Page memories, registered read.
    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            r_mem_next[w_next_addr] <= w_next_wd;
        end
        r_rd_next <= r_mem_next[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_prev_we) begin
            r_mem_prev[w_prev_addr] <= w_prev_wd;
        end
        r_rd_prev <= r_mem_prev[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_mem_meta[w_meta_addr] <= w_meta_wd;
        end
        r_rd_meta <= r_mem_meta[w_rd_addr];
        r_rd_addr <= w_rd_addr;
    end

    // Next sequencer state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == PW'(bpa_pkg::NUM_PAGES - 1)) n_state = S_BUILD;
            S_BUILD: begin
                if (r_left >= w_sz_cur) begin
                    n_state = S_PUSHA;
                end else if (r_cur == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_block_order > OW'(bpa_pkg::TOP_ORDER)) begin
                        n_state = S_DONE;
                    end else if (i_opcode == bpa_pkg::OP_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (((LW'(i_page_index) & (w_sz_in - LW'(1))) != '0) ||
                                 ((LW'(i_page_index) + w_sz_in) > r_pool)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FCHK;
                    end
                end
            end
            S_SCAN: begin
                if (r_cur > OW'(bpa_pkg::TOP_ORDER)) begin
                    n_state = S_DONE;
                end else if (w_head_cur != bpa_pkg::NIL_LINK) begin
                    n_state = S_UNL;
                end
            end
            S_UNL:   n_state = S_SPLIT;
            S_SPLIT: n_state = (r_cur > r_ord) ? S_PUSHA : S_DONE;
            S_FCHK:  n_state = r_rd_meta[OW] ? S_DONE : S_MTEST;
            S_MTEST: begin
                if ((r_cur < OW'(bpa_pkg::TOP_ORDER)) && ({1'b0, w_bd} < r_pool)) begin
                    n_state = S_MRG;
                end else begin
                    n_state = S_PUSHA;
                end
            end
            S_MRG:   n_state = w_merge ? S_MTEST : S_PUSHA;
            S_PUSHA: n_state = S_PUSHB;
            S_PUSHB: n_state = r_ret;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (w_cfg_wr) begin
            n_state = S_CLEAR;
        end
    end

    // Sequencer registers and list heads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pool  <= bpa_pkg::NIL_LINK;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PW'(1);
                    for (int i = 0; i < bpa_pkg::HEADS; i++) begin
                        r_head[i] <= bpa_pkg::NIL_LINK;
                    end
                    r_cur   <= OW'(bpa_pkg::TOP_ORDER);
                    r_base  <= '0;
                    r_left  <= r_pool;
                    r_count <= r_pool;
                end
                S_BUILD: begin
                    if (r_left >= w_sz_cur) begin
                        r_push_ord <= r_cur;
                        r_push_pg  <= r_base[PW-1:0];
                        r_ret      <= S_BUILD;
                        r_base     <= r_base + w_sz_cur;
                        r_left     <= r_left - w_sz_cur;
                    end else if (r_cur != '0) begin
                        r_cur <= r_cur - OW'(1);
                    end
                end
                S_IDLE: begin
                    r_ord    <= i_block_order;
                    r_cur    <= i_block_order;
                    r_p      <= i_page_index;
                    r_blk    <= '0;
                    r_status <= (i_block_order > OW'(bpa_pkg::TOP_ORDER)) ?
                                bpa_pkg::ST_BAD_ORD : bpa_pkg::ST_BAD_PAGE;
                end
                S_SCAN: begin
                    if (r_cur > OW'(bpa_pkg::TOP_ORDER)) begin
                        r_status <= bpa_pkg::ST_NO_MEM;
                    end else if (w_head_cur == bpa_pkg::NIL_LINK) begin
                        r_cur <= r_cur + OW'(1);
                    end else begin
                        r_p <= w_head_cur[PW-1:0];
                    end
                end
                S_SPLIT: begin
                    if (r_cur > r_ord) begin
                        r_cur      <= r_cur - OW'(1);
                        r_push_ord <= r_cur - OW'(1);
                        r_push_pg  <= w_split_pg;
                        r_ret      <= S_SPLIT;
                    end else begin
                        r_count  <= r_count - w_sz_ord;
                        r_blk    <= r_p;
                        r_status <= bpa_pkg::ST_OK;
                    end
                end
                S_MTEST: begin
                    if (!((r_cur < OW'(bpa_pkg::TOP_ORDER)) && ({1'b0, w_bd} < r_pool))) begin
                        r_push_ord <= r_cur;
                        r_push_pg  <= r_p;
                        r_ret      <= S_DONE;
                        r_count    <= w_free_cnt;
                        r_status   <= bpa_pkg::ST_OK;
                    end
                end
                S_MRG: begin
                    if (w_merge) begin
                        r_p   <= r_p & ~w_merge_mask;
                        r_cur <= r_cur + OW'(1);
                    end else begin
                        r_push_ord <= r_cur;
                        r_push_pg  <= r_p;
                        r_ret      <= S_DONE;
                        r_count    <= w_free_cnt;
                        r_status   <= bpa_pkg::ST_OK;
                    end
                end
                S_PUSHA: begin
                    r_push_h             <= r_head[r_push_ord];
                    r_head[r_push_ord]   <= {1'b0, r_push_pg};
                end
                default: ;
            endcase
            // Advance the list head past an unlinked first block.
            if (w_unl && (r_rd_prev == bpa_pkg::NIL_LINK)) begin
                r_head[r_rd_meta[OW-1:0]] <= r_rd_next;
            end
            if (w_cfg_wr) begin
                r_pool <= w_cfg_val;
                r_clr  <= '0;
            end
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = (r_state == S_DONE);
    assign o_status     = r_status;
    assign o_block_page = r_blk;
    assign o_free_pages = r_count;

endmodule

### src/bpa_checker.sv
// Port-level checker for the buddy page allocator, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [11:0] o_block_page,
    input logic [12:0] o_free_pages
);
    // A result only appears while a command is in flight.
    `AST_IMPL(a_done_busy, i_clk, i_rst_n, o_done, busy)
    // An accepted command holds the block busy.
    `AST_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // Failed commands report page zero.
    `AST_IMPL(a_fail_zero, i_clk, i_rst_n, o_done && (o_status != bpa_pkg::ST_OK), o_block_page == '0)
    // The result strobe lasts one cycle.
    `AST_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    // At each result, the free count does not exceed the pool capacity.
    `AST_IMPL(a_count_cap, i_clk, i_rst_n, o_done, o_free_pages <= 13'(bpa_pkg::NUM_PAGES))
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_block_page (o_block_page),
    .o_free_pages (o_free_pages)
);
